>>> src/shmc_pkg.sv
package shmc_pkg;

  // register indexes of the configuration port
  typedef enum logic [0:0] {
    CFG_PHASE_TABLE = 1'b0,
    CFG_STEP_PERIOD = 1'b1
  } shmc_cfg_idx_e;

  // input op codes
  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_MOVE = 2'd1,
    OP_STOP = 2'd2
  } shmc_op_e;

  // classified command kinds between front and back
  typedef enum logic [1:0] {
    KIND_TICK = 2'd0,
    KIND_MOVE = 2'd1,
    KIND_STOP = 2'd2,
    KIND_IGNORE = 2'd3
  } shmc_kind_e;

  // decoded end switch state, minus wins over plus
  typedef enum logic [1:0] {
    SW_NONE  = 2'd0,
    SW_MINUS = 2'd1,
    SW_PLUS  = 2'd2
  } shmc_sw_e;

  typedef enum logic [1:0] {
    ST_NONE   = 2'd0,
    ST_ACCEPT = 2'd1,
    ST_REJECT = 2'd2
  } shmc_status_e;

  typedef enum logic [1:0] {
    REP_MINUS = 2'd1,
    REP_PLUS  = 2'd2,
    REP_CLEAR = 2'd3
  } shmc_rep_e;

  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [2:0]  PHASE_TABLE_RST = 3'd1;
  localparam logic [15:0] STEP_PERIOD_RST = 16'd1000;
  localparam logic [2:0]  IDX_LAST = 3'd7;

  localparam logic [3:0] PHASE_ROM [8][8] = '{
    '{4'h8, 4'hC, 4'h4, 4'h6, 4'h2, 4'h3, 4'h1, 4'h9},
    '{4'h2, 4'h6, 4'h4, 4'hC, 4'h8, 4'h9, 4'h1, 4'h3},
    '{4'h8, 4'h9, 4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hC},
    '{4'h8, 4'hA, 4'h2, 4'h6, 4'h4, 4'h5, 4'h1, 4'h9},
    '{4'h7, 4'h3, 4'hB, 4'h9, 4'hD, 4'hC, 4'hE, 4'h6},
    '{4'hD, 4'h9, 4'hB, 4'h3, 4'h7, 4'h6, 4'hE, 4'hC},
    '{4'h7, 4'h6, 4'hE, 4'hC, 4'hD, 4'h9, 4'hB, 4'h3},
    '{4'h7, 4'h5, 4'hD, 4'h9, 4'hB, 4'hA, 4'hE, 4'h6}
  };

  typedef struct packed {
    logic [1:0]         op;
    logic [3:0]         motor;
    logic signed [15:0] steps;
    logic               switch_plus;
    logic               switch_minus;
  } shmc_in_t;

  typedef struct packed {
    logic [3:0] phase;
    logic [3:0] motor_enable;
    logic [1:0] cmd_status;
    logic       report_valid;
    logic [2:0] report_motor;
    logic [1:0] report_code;
    logic       busy_res;
  } shmc_out_t;

  // one classified beat as queued between front and back
  typedef struct packed {
    shmc_kind_e  kind;
    logic        motor_ok;
    logic [2:0]  motor;
    logic        neg;
    logic        zero;
    logic [15:0] mag;
    shmc_sw_e    sw;
  } shmc_cmd_t;

endpackage

>>> src/shmc_front.sv
module shmc_front #(
  parameter int unsigned NUM_MOTORS = 4
) (
  input  shmc_pkg::shmc_in_t  in_data_i,
  output shmc_pkg::shmc_cmd_t cmd_o
);
  import shmc_pkg::*;

  logic [15:0] raw;

  assign raw = in_data_i.steps;

  always_comb begin
    cmd_o.kind = KIND_IGNORE;
    unique case (in_data_i.op)
      OP_TICK: cmd_o.kind = KIND_TICK;
      OP_MOVE: cmd_o.kind = KIND_MOVE;
      OP_STOP: cmd_o.kind = KIND_STOP;
      default: cmd_o.kind = KIND_IGNORE;
    endcase

    cmd_o.motor_ok = (in_data_i.motor != 4'd0) && (in_data_i.motor <= 4'(NUM_MOTORS));
    cmd_o.motor    = in_data_i.motor[2:0];
    cmd_o.neg      = raw[15];
    cmd_o.zero     = (raw == 16'd0);
    // magnitude; the most negative count wraps to 0x8000, which is its magnitude
    cmd_o.mag      = raw[15] ? (16'd0 - raw) : raw;

    priority if (in_data_i.switch_minus) cmd_o.sw = SW_MINUS;
    else if (in_data_i.switch_plus)      cmd_o.sw = SW_PLUS;
    else                                 cmd_o.sw = SW_NONE;
  end

endmodule

>>> src/shmc_queue.sv
module shmc_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  shmc_pkg::shmc_cmd_t push_data_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                empty_o,
  output shmc_pkg::shmc_cmd_t pop_data_o
);
  import shmc_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  shmc_cmd_t        mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign full_o     = (count_q == CNT_W'(DEPTH));
  assign empty_o    = (count_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage cleared so the back never decodes an unknown entry while empty
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mem_q <= '{default: '0};
    end else if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

>>> src/shmc_back.sv
module shmc_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [2:0]          phase_table_i,
  input  logic [15:0]         step_period_i,
  input  logic                cmd_valid_i,
  input  shmc_pkg::shmc_cmd_t cmd_i,
  output logic                cmd_pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output shmc_pkg::shmc_out_t out_data_o
);
  import shmc_pkg::*;

  logic [15:0] steps_q, steps_d;
  logic [2:0]  idx_q, idx_d;
  logic        rev_q, rev_d;
  logic [2:0]  active_q, active_d;
  logic [15:0] period_q, period_d;
  logic [3:0]  phase_q, phase_d;
  logic [3:0]  enable_q, enable_d;
  logic        out_valid_q;
  shmc_out_t   out_q, out_d;

  logic         busy, fire, hit, do_halt;
  logic [2:0]   halt_motor;
  logic [15:0]  steps_dec;
  shmc_status_e status;
  logic         rep_valid;
  logic [2:0]   rep_motor;
  logic [1:0]   rep_code;

  assign busy      = (steps_q != 16'd0);
  assign fire      = (period_q >= step_period_i);
  assign steps_dec = steps_q - 16'd1;
  assign cmd_pop_o = cmd_valid_i && (!out_valid_q || out_ready_i);

  always_comb begin
    steps_d    = steps_q;
    idx_d      = idx_q;
    rev_d      = rev_q;
    active_d   = active_q;
    period_d   = period_q;
    phase_d    = phase_q;
    enable_d   = enable_q;
    status     = ST_NONE;
    rep_valid  = 1'b0;
    rep_motor  = 3'd0;
    rep_code   = 2'd0;
    do_halt    = 1'b0;
    halt_motor = active_q;
    hit        = 1'b0;

    unique case (cmd_i.kind)
      KIND_TICK: begin
        if (busy) begin
          if (fire) begin
            period_d = 16'd0;
            phase_d  = PHASE_ROM[phase_table_i][idx_q];
            if (rev_q) begin
              if (idx_q == 3'd0) begin
                idx_d   = IDX_LAST;
                steps_d = steps_dec;
              end else begin
                idx_d = idx_q - 3'd1;
              end
            end else begin
              if (idx_q == IDX_LAST) begin
                idx_d   = 3'd0;
                steps_d = steps_dec;
              end else begin
                idx_d = idx_q + 3'd1;
              end
            end
            hit = (rev_q && cmd_i.sw == SW_MINUS) || (!rev_q && cmd_i.sw == SW_PLUS);
            if (hit || steps_d == 16'd0) begin
              do_halt = 1'b1;
            end
          end else begin
            period_d = period_q + 16'd1;
          end
        end
      end
      KIND_MOVE: begin
        if (!cmd_i.motor_ok || busy) begin
          status = ST_REJECT;
        end else if (cmd_i.zero) begin
          // zero count only reports the switches of that motor
          rep_valid = 1'b1;
          rep_motor = cmd_i.motor;
          rep_code  = (cmd_i.sw == SW_NONE) ? REP_CLEAR : cmd_i.sw;
          phase_d   = 4'd0;
          enable_d  = 4'd0;
          active_d  = 3'd0;
          status    = ST_REJECT;
        end else if ((cmd_i.sw == SW_MINUS && cmd_i.neg) ||
                     (cmd_i.sw == SW_PLUS && !cmd_i.neg)) begin
          do_halt    = 1'b1;
          halt_motor = cmd_i.motor;
          status     = ST_REJECT;
        end else begin
          phase_d  = 4'd0;
          enable_d = 4'd1 << (cmd_i.motor - 3'd1);
          active_d = cmd_i.motor;
          rev_d    = cmd_i.neg;
          steps_d  = cmd_i.mag;
          period_d = 16'd0;
          status   = ST_ACCEPT;
        end
      end
      KIND_STOP: begin
        do_halt = 1'b1;
      end
      KIND_IGNORE: begin
      end
    endcase

    if (do_halt) begin
      if (halt_motor != 3'd0) begin
        rep_valid = 1'b1;
        rep_motor = halt_motor;
        rep_code  = (cmd_i.sw == SW_NONE) ? REP_CLEAR : cmd_i.sw;
      end
      phase_d  = 4'd0;
      enable_d = 4'd0;
      steps_d  = 16'd0;
      idx_d    = 3'd0;
      active_d = 3'd0;
      period_d = 16'd0;
    end

    out_d.phase        = phase_d;
    out_d.motor_enable = enable_d;
    out_d.cmd_status   = status;
    out_d.report_valid = rep_valid;
    out_d.report_motor = rep_motor;
    out_d.report_code  = rep_code;
    out_d.busy_res     = (steps_d != 16'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      steps_q     <= '0;
      idx_q       <= '0;
      rev_q       <= 1'b0;
      active_q    <= '0;
      period_q    <= '0;
      phase_q     <= '0;
      enable_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_pop_o) begin
        steps_q  <= steps_d;
        idx_q    <= idx_d;
        rev_q    <= rev_d;
        active_q <= active_d;
        period_q <= period_d;
        phase_q  <= phase_d;
        enable_q <= enable_d;
      end
      if (cmd_pop_o) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> src/stepper_half_step_move_controller.sv
// Half-step move controller for up to NUM_MOTORS stepper motors. Each input beat is a base
// tick, a move command or a forced stop, and each one yields exactly one result beat with the
// winding nibble, the one-hot motor enable, the command status, an optional end switch report
// and the busy flag. Throughput is one beat per clock while the output side is not stalled:
// the front decodes a beat in the cycle it is accepted and writes it into a two-entry queue,
// and the back applies one queued beat per cycle to the move state (period counter,
// microstep index, step count) and registers the result. A result beat passes through the
// queue entry and then the output register; the queue and the output register absorb a
// stall on either side before the other side is held. The user must write the phase table
// and step period registers only while no beat is in flight; the block does not enforce it.
module stepper_half_step_move_controller #(
  parameter int unsigned NUM_MOTORS = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration writes
  input  logic                cfg_we_i,
  input  logic [0:0]          cfg_index_i,
  input  logic [15:0]         cfg_data_i,
  // input beats
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  shmc_pkg::shmc_in_t  in_data_i,
  // result beats
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output shmc_pkg::shmc_out_t out_data_o
);
  import shmc_pkg::*;

  localparam int unsigned QUEUE_DEPTH = 2;

  logic [2:0]  phase_table_q;
  logic [15:0] step_period_q;

  shmc_cmd_t front_cmd;
  shmc_cmd_t back_cmd;
  logic      q_full, q_empty, q_pop;

  // configuration registers, taken straight off the write port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_table_q <= PHASE_TABLE_RST;
      step_period_q <= STEP_PERIOD_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_PHASE_TABLE: phase_table_q <= cfg_data_i[2:0];
        CFG_STEP_PERIOD: step_period_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // front: classify op, decode switches, check motor number, take step magnitude
  shmc_front #(
    .NUM_MOTORS(NUM_MOTORS)
  ) u_front (
    .in_data_i(in_data_i),
    .cmd_o    (front_cmd)
  );

  // input is taken whenever the queue has a free slot
  assign in_ready_o = !q_full;

  shmc_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (in_valid_i),
    .push_data_i(front_cmd),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .empty_o    (q_empty),
    .pop_data_o (back_cmd)
  );

  // back: move state machine plus output register
  shmc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .phase_table_i(phase_table_q),
    .step_period_i(step_period_q),
    .cmd_valid_i  (!q_empty),
    .cmd_i        (back_cmd),
    .cmd_pop_o    (q_pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

endmodule

>>> src/shmc_checker.sv
module shmc_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input shmc_pkg::shmc_out_t out_data_o
);
  import shmc_pkg::*;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed while stalled");

  // a report names a motor and carries a code; no report leaves both fields clear
  a_report_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.report_valid ?
      (out_data_o.report_motor != 3'd0 && out_data_o.report_code != 2'd0) :
      (out_data_o.report_motor == 3'd0 && out_data_o.report_code == 2'd0)))
    else $error("report fields inconsistent");

  // an accepted move leaves exactly one motor enabled and steps pending
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.cmd_status == ST_ACCEPT |->
      out_data_o.busy_res && $onehot(out_data_o.motor_enable) && !out_data_o.report_valid)
    else $error("accepted move without a running motor");

  // windings are only driven during a move, and never more than one motor enabled
  a_phase_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $onehot0(out_data_o.motor_enable) &&
      (out_data_o.phase == 4'd0 || out_data_o.busy_res))
    else $error("windings driven while idle");

endmodule

bind stepper_half_step_move_controller shmc_checker u_shmc_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o (out_data_o)
);
